>>> design/lsdm_pkg.sv
// ----------------------------------------------------------------------------
// lsdm_pkg
// Shared constants for the laser scan distance map unit: map size, beam and
// range limits, action and register codes, and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package lsdm_pkg;

    localparam int MAP_CELLS  = 16384;
    localparam int ADDR_W     = $clog2(MAP_CELLS);
    localparam int MAX_RADIUS = 7;
    localparam int MAX_BEAMS  = 360;
    localparam int MAX_RANGE  = 30000;
    localparam int MAX_ANGLE  = 90;

    localparam logic [15:0] UNKNOWN_DIST = 16'hFFFF;

    localparam logic [1:0] ACT_SCAN = 2'd0;
    localparam logic [1:0] ACT_BEAM = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [2:0] REG_CELL_SIZE     = 3'd0;
    localparam logic [2:0] REG_MAP_WIDTH     = 3'd1;
    localparam logic [2:0] REG_MAP_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_OFFSET_X      = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y      = 3'd4;
    localparam logic [2:0] REG_WINDOW_RADIUS = 3'd5;
    localparam logic [2:0] REG_MIN_RANGE     = 3'd6;
    localparam logic [2:0] REG_BEAM_CENTER   = 3'd7;

    typedef logic [ADDR_W-1:0] addr_t;

    localparam logic [14:0] SIN_DEG [0:90] = '{
        15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
        15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
        15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
        15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
        15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
        15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
        15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
        15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
        15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
        15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    function automatic logic [14:0] sin_deg(input logic [6:0] deg);
        logic [14:0] val;
        begin
            val = 15'd0;
            if (deg <= 7'(MAX_ANGLE))
            begin
                val = SIN_DEG[deg];
            end
            return val;
        end
    endfunction

endpackage

>>> design/laser_scan_distance_map_unit.sv
// ----------------------------------------------------------------------------
// laser_scan_distance_map_unit
// Local obstacle distance grid in one 16384 x 16 synchronous memory. Beams
// are projected with one shared 17 x 17 multiplier, quantized by a serial
// divider and stamped into the grid by read, square root, compare, write.
//
// Channel   | Handshake          | Payload
// ----------+--------------------+--------------------------------------------
// item in   | start, busy        | action, beam_index, range_mm, pose_*,
//           |                    | cell_index
// result    | done (one cycle)   | cell_distance, beam_used, hit_cell
// config    | cfg_we             | cfg_index, cfg_data
//
// A read item keeps busy high through ST_READ and ST_READ_OUT, and done
// rises as busy falls. A scan start sweeps the memory, writing unknown.
// A beam runs projection and division, then the read, serial square root,
// compare and write for each window cell inside the map. After reset busy
// stays high for a sweep that fills the memory with unknown. Results cannot
// be held off.
// ----------------------------------------------------------------------------
module laser_scan_distance_map_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            action,
    input  logic [8:0]            beam_index,
    input  logic [15:0]           range_mm,
    input  logic signed [15:0]    pose_cos,
    input  logic signed [15:0]    pose_sin,
    input  logic signed [15:0]    pose_x,
    input  logic signed [15:0]    pose_y,
    input  lsdm_pkg::addr_t       cell_index,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output logic                  done,
    output logic [15:0]           cell_distance,
    output logic                  beam_used,
    output lsdm_pkg::addr_t       hit_cell
);
    import lsdm_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_READ     = 4'd2;
    localparam logic [3:0] ST_READ_OUT = 4'd3;
    localparam logic [3:0] ST_CHECK    = 4'd4;
    localparam logic [3:0] ST_MUL      = 4'd5;
    localparam logic [3:0] ST_DIVINIT  = 4'd6;
    localparam logic [3:0] ST_DIV      = 4'd7;
    localparam logic [3:0] ST_INDEX    = 4'd8;
    localparam logic [3:0] ST_WADDR    = 4'd9;
    localparam logic [3:0] ST_WSQRT    = 4'd10;
    localparam logic [3:0] ST_WWRITE   = 4'd11;

    logic [15:0] grid [0:MAP_CELLS-1];
    logic [15:0] mem_q;
    addr_t       mem_addr;
    logic        mem_we;
    logic [15:0] mem_wdata;

    logic [9:0]         cell_size_reg;
    logic [8:0]         map_width_reg;
    logic [8:0]         map_height_reg;
    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;
    logic [2:0]         window_radius_reg;
    logic [15:0]        min_range_reg;
    logic [8:0]         beam_center_reg;

    logic [3:0]         state_reg, state_next;
    logic signed [15:0] hc_reg, hc_next, hs_reg, hs_next;
    logic signed [15:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [8:0]         beam_index_reg, beam_index_next;
    logic [15:0]        range_mm_reg, range_mm_next;
    addr_t              cell_index_reg, cell_index_next;
    addr_t              clr_cnt_reg, clr_cnt_next;
    logic               clr_item_reg, clr_item_next;
    logic signed [16:0] c_reg, c_next, s_reg, s_next;
    logic [9:0]         cs_reg, cs_next;
    logic [19:0]        cs_sq_reg, cs_sq_next;
    logic [3:0]         step_reg, step_next;
    logic signed [33:0] prod_reg, prod_next;
    logic signed [31:0] xd_reg, xd_next, yd_reg, yd_next;
    logic signed [47:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic               div_sel_reg, div_sel_next;
    logic [4:0]         div_cnt_reg, div_cnt_next;
    logic [9:0]         div_rem_reg, div_rem_next;
    logic [18:0]        div_quo_reg, div_quo_next;
    logic [18:0]        cx_reg, cx_next, cy_reg, cy_next;
    addr_t              v_reg, v_next;
    logic signed [3:0]  k_reg, k_next, l_reg, l_next;
    addr_t              m_reg, m_next;
    logic [27:0]        sq_rem_reg, sq_rem_next;
    logic [27:0]        sq_f_reg, sq_f_next;
    logic [27:0]        sq_bit_reg, sq_bit_next;
    logic [3:0]         sq_cnt_reg, sq_cnt_next;
    logic               done_reg, done_next;
    logic [15:0]        dist_reg, dist_next;
    logic               used_reg, used_next;
    addr_t              hit_reg, hit_next;

    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    logic signed [47:0] prod_ext;
    logic signed [9:0]  ang;
    logic [9:0]         mag;
    logic               beam_ok;
    logic signed [16:0] pos_sum_x, pos_sum_y;
    logic signed [47:0] div_src;
    logic [10:0]        div_try;
    logic               div_bit;
    logic [17:0]        v_full;
    logic signed [13:0] lw;
    logic signed [18:0] m_full;
    logic [2:0]         k_abs, l_abs;
    logic [6:0]         ksq;
    logic [27:0]        sq_trial;
    logic [15:0]        d_val;
    logic signed [3:0]  rad, rad_neg;
    logic               win_last;

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign cell_distance = dist_reg;
    assign beam_used     = used_reg;
    assign hit_cell      = hit_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid[mem_addr] <= mem_wdata;
        end
        mem_q <= grid[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg     <= 10'd50;
            map_width_reg     <= 9'd128;
            map_height_reg    <= 9'd128;
            offset_x_reg      <= 16'sd3200;
            offset_y_reg      <= 16'sd3200;
            window_radius_reg <= 3'd3;
            min_range_reg     <= 16'd100;
            beam_center_reg   <= 9'd180;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELL_SIZE:     cell_size_reg     <= cfg_data[9:0];
                REG_MAP_WIDTH:     map_width_reg     <= cfg_data[8:0];
                REG_MAP_HEIGHT:    map_height_reg    <= cfg_data[8:0];
                REG_OFFSET_X:      offset_x_reg      <= cfg_data;
                REG_OFFSET_Y:      offset_y_reg      <= cfg_data;
                REG_WINDOW_RADIUS: window_radius_reg <= cfg_data[2:0];
                REG_MIN_RANGE:     min_range_reg     <= cfg_data;
                REG_BEAM_CENTER:   beam_center_reg   <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_item_reg <= 1'b0;
            done_reg     <= 1'b0;
            hc_reg       <= 16'sd16384;
            hs_reg       <= '0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_item_reg <= clr_item_next;
            done_reg     <= done_next;
            hc_reg       <= hc_next;
            hs_reg       <= hs_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beam_index_reg <= beam_index_next;
        range_mm_reg   <= range_mm_next;
        cell_index_reg <= cell_index_next;
        c_reg          <= c_next;
        s_reg          <= s_next;
        cs_reg         <= cs_next;
        cs_sq_reg      <= cs_sq_next;
        step_reg       <= step_next;
        prod_reg       <= prod_next;
        xd_reg         <= xd_next;
        yd_reg         <= yd_next;
        acc_x_reg      <= acc_x_next;
        acc_y_reg      <= acc_y_next;
        div_sel_reg    <= div_sel_next;
        div_cnt_reg    <= div_cnt_next;
        div_rem_reg    <= div_rem_next;
        div_quo_reg    <= div_quo_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        v_reg          <= v_next;
        k_reg          <= k_next;
        l_reg          <= l_next;
        m_reg          <= m_next;
        sq_rem_reg     <= sq_rem_next;
        sq_f_reg       <= sq_f_next;
        sq_bit_reg     <= sq_bit_next;
        sq_cnt_reg     <= sq_cnt_next;
        dist_reg       <= dist_next;
        used_reg       <= used_next;
        hit_reg        <= hit_next;
    end

    always_comb
    begin
        case (step_reg)
            4'd0:    begin mul_a = $signed({1'b0, range_mm_reg}); mul_b = c_reg; end
            4'd1:    begin mul_a = $signed({1'b0, range_mm_reg}); mul_b = s_reg; end
            4'd2:    begin mul_a = 17'(hc_reg); mul_b = $signed({1'b0, xd_reg[15:0]}); end
            4'd3:    begin mul_a = 17'(hc_reg); mul_b = 17'($signed(xd_reg[31:16])); end
            4'd4:    begin mul_a = 17'(hs_reg); mul_b = $signed({1'b0, yd_reg[15:0]}); end
            4'd5:    begin mul_a = 17'(hs_reg); mul_b = 17'($signed(yd_reg[31:16])); end
            4'd6:    begin mul_a = 17'(hs_reg); mul_b = $signed({1'b0, xd_reg[15:0]}); end
            4'd7:    begin mul_a = 17'(hs_reg); mul_b = 17'($signed(xd_reg[31:16])); end
            4'd8:    begin mul_a = 17'(hc_reg); mul_b = $signed({1'b0, yd_reg[15:0]}); end
            4'd9:    begin mul_a = 17'(hc_reg); mul_b = 17'($signed(yd_reg[31:16])); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        ang       = $signed({1'b0, beam_index_reg}) - $signed({1'b0, beam_center_reg});
        mag       = ang[9] ? 10'(-ang) : 10'(ang);
        beam_ok   = (beam_index_reg < 9'(MAX_BEAMS)) && (mag <= 10'(MAX_ANGLE))
                    && (range_mm_reg > min_range_reg)
                    && (range_mm_reg < 16'(MAX_RANGE));
        pos_sum_x = 17'(pos_x_reg) + 17'(offset_x_reg);
        pos_sum_y = 17'(pos_y_reg) + 17'(offset_y_reg);

        if (!step_reg[0] && (step_reg >= 4'd4))
        begin
            prod_ext = $signed({prod_reg[31:0], 16'b0});
        end
        else
        begin
            prod_ext = 48'(prod_reg);
        end

        div_src = div_sel_reg ? acc_y_reg : acc_x_reg;
        div_try = {div_rem_reg, div_quo_reg[18]};
        div_bit = (div_try >= {1'b0, cs_reg});

        v_full = 18'(cy_reg[7:0] * map_width_reg) + 18'(cx_reg[8:0]);

        lw      = l_reg * $signed({1'b0, map_width_reg});
        m_full  = $signed({5'b0, v_reg}) + lw + k_reg;
        k_abs   = k_reg[3] ? 3'(-k_reg) : k_reg[2:0];
        l_abs   = l_reg[3] ? 3'(-l_reg) : l_reg[2:0];
        ksq     = 7'(k_abs * k_abs) + 7'(l_abs * l_abs);

        sq_trial = sq_f_reg + sq_bit_reg;
        d_val    = (sq_rem_reg > sq_f_reg) ? 16'(sq_f_reg + 28'd1) : sq_f_reg[15:0];

        rad      = $signed({1'b0, window_radius_reg});
        rad_neg  = -rad;
        win_last = (l_reg == rad) && (k_reg == rad);
    end

    always_comb
    begin
        state_next      = state_reg;
        hc_next         = hc_reg;
        hs_next         = hs_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        beam_index_next = beam_index_reg;
        range_mm_next   = range_mm_reg;
        cell_index_next = cell_index_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_item_next   = clr_item_reg;
        c_next          = c_reg;
        s_next          = s_reg;
        cs_next         = cs_reg;
        cs_sq_next      = cs_sq_reg;
        step_next       = step_reg;
        prod_next       = prod_reg;
        xd_next         = xd_reg;
        yd_next         = yd_reg;
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        div_sel_next    = div_sel_reg;
        div_cnt_next    = div_cnt_reg;
        div_rem_next    = div_rem_reg;
        div_quo_next    = div_quo_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        v_next          = v_reg;
        k_next          = k_reg;
        l_next          = l_reg;
        m_next          = m_reg;
        sq_rem_next     = sq_rem_reg;
        sq_f_next       = sq_f_reg;
        sq_bit_next     = sq_bit_reg;
        sq_cnt_next     = sq_cnt_reg;
        done_next       = 1'b0;
        dist_next       = dist_reg;
        used_next       = used_reg;
        hit_next        = hit_reg;
        mem_addr        = m_reg;
        mem_we          = 1'b0;
        mem_wdata       = UNKNOWN_DIST;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    beam_index_next = beam_index;
                    range_mm_next   = range_mm;
                    cell_index_next = cell_index;
                    case (action)
                        ACT_SCAN:
                        begin
                            hc_next       = pose_cos;
                            hs_next       = pose_sin;
                            pos_x_next    = pose_x;
                            pos_y_next    = pose_y;
                            clr_cnt_next  = '0;
                            clr_item_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        ACT_BEAM: state_next = ST_CHECK;
                        ACT_READ: state_next = ST_READ;
                        default:
                        begin
                            done_next = 1'b1;
                            dist_next = '0;
                            used_next = 1'b0;
                            hit_next  = '0;
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                mem_addr     = clr_cnt_reg;
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next    = ST_IDLE;
                    clr_item_next = 1'b0;
                    if (clr_item_reg)
                    begin
                        done_next = 1'b1;
                        dist_next = '0;
                        used_next = 1'b0;
                        hit_next  = '0;
                    end
                end
            end

            ST_READ:
            begin
                mem_addr   = cell_index_reg;
                state_next = ST_READ_OUT;
            end

            ST_READ_OUT:
            begin
                done_next  = 1'b1;
                dist_next  = mem_q;
                used_next  = 1'b0;
                hit_next   = '0;
                state_next = ST_IDLE;
            end

            ST_CHECK:
            begin
                if (!beam_ok)
                begin
                    done_next  = 1'b1;
                    dist_next  = '0;
                    used_next  = 1'b0;
                    hit_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    c_next     = $signed({2'b0, sin_deg(7'(10'(MAX_ANGLE) - mag))});
                    s_next     = ang[9] ? -$signed({2'b0, sin_deg(mag[6:0])})
                                        : $signed({2'b0, sin_deg(mag[6:0])});
                    cs_next    = (cell_size_reg == '0) ? 10'd1 : cell_size_reg;
                    acc_x_next = $signed({{3{pos_sum_x[16]}}, pos_sum_x, 28'b0});
                    acc_y_next = $signed({{3{pos_sum_y[16]}}, pos_sum_y, 28'b0});
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                cs_sq_next = cs_reg * cs_reg;
                prod_next  = mul_p;
                step_next  = step_reg + 1'b1;
                case (step_reg)
                    4'd0:          ;
                    4'd1:          xd_next = prod_reg[31:0];
                    4'd2:          yd_next = prod_reg[31:0];
                    4'd3, 4'd4:    acc_x_next = acc_x_reg + prod_ext;
                    4'd5, 4'd6:    acc_x_next = acc_x_reg - prod_ext;
                    4'd7, 4'd8, 4'd9, 4'd10:
                                   acc_y_next = acc_y_reg + prod_ext;
                    default:       ;
                endcase
                if (step_reg == 4'd10)
                begin
                    div_sel_next = 1'b0;
                    state_next   = ST_DIVINIT;
                end
            end

            ST_DIVINIT:
            begin
                if (div_src[47])
                begin
                    done_next  = 1'b1;
                    dist_next  = '0;
                    used_next  = 1'b0;
                    hit_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_rem_next = '0;
                    div_quo_next = div_src[46:28];
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end

            ST_DIV:
            begin
                div_rem_next = div_bit ? 10'(div_try - {1'b0, cs_reg}) : div_try[9:0];
                div_quo_next = {div_quo_reg[17:0], div_bit};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 5'd18)
                begin
                    if (!div_sel_reg)
                    begin
                        cx_next      = {div_quo_reg[17:0], div_bit};
                        div_sel_next = 1'b1;
                        state_next   = ST_DIVINIT;
                    end
                    else
                    begin
                        cy_next    = {div_quo_reg[17:0], div_bit};
                        state_next = ST_INDEX;
                    end
                end
            end

            ST_INDEX:
            begin
                if ((cx_reg >= {10'b0, map_width_reg}) || (cy_reg >= {10'b0, map_height_reg})
                    || (v_full >= 18'(MAP_CELLS)))
                begin
                    done_next  = 1'b1;
                    dist_next  = '0;
                    used_next  = 1'b0;
                    hit_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    v_next     = v_full[ADDR_W-1:0];
                    k_next     = rad_neg;
                    l_next     = rad_neg;
                    state_next = ST_WADDR;
                end
            end

            ST_WADDR:
            begin
                if (!m_full[18] && (m_full < 19'(MAP_CELLS)))
                begin
                    mem_addr    = m_full[ADDR_W-1:0];
                    m_next      = m_full[ADDR_W-1:0];
                    sq_rem_next = 28'(ksq * cs_sq_reg);
                    sq_f_next   = '0;
                    sq_bit_next = 28'd1 << 26;
                    sq_cnt_next = '0;
                    state_next  = ST_WSQRT;
                end
                else if (win_last)
                begin
                    done_next  = 1'b1;
                    dist_next  = '0;
                    used_next  = 1'b1;
                    hit_next   = v_reg;
                    state_next = ST_IDLE;
                end
                else if (l_reg == rad)
                begin
                    l_next = rad_neg;
                    k_next = k_reg + 4'sd1;
                end
                else
                begin
                    l_next = l_reg + 4'sd1;
                end
            end

            ST_WSQRT:
            begin
                if (sq_rem_reg >= sq_trial)
                begin
                    sq_rem_next = sq_rem_reg - sq_trial;
                    sq_f_next   = (sq_f_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_f_next = sq_f_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 4'd13)
                begin
                    state_next = ST_WWRITE;
                end
            end

            ST_WWRITE:
            begin
                mem_wdata = d_val;
                mem_we    = (d_val < mem_q);
                if (win_last)
                begin
                    done_next  = 1'b1;
                    dist_next  = '0;
                    used_next  = 1'b1;
                    hit_next   = v_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WADDR;
                    if (l_reg == rad)
                    begin
                        l_next = rad_neg;
                        k_next = k_reg + 4'sd1;
                    end
                    else
                    begin
                        l_next = l_reg + 4'sd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
